FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file ualu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/core/ualu_pkg.sv
// ----------------------------------------------------------------------------
// ualu_pkg
// Action codes, command record and compare codes for the unsigned integer unit.
// ----------------------------------------------------------------------------
package ualu_pkg;
	localparam int unsigned ActW   = 4;
	localparam int unsigned FieldW = 64;

	typedef enum logic [ActW-1:0] {
		ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_AND = 4'd2, ACT_OR = 4'd3,
		ACT_XOR = 4'd4, ACT_NOT = 4'd5, ACT_SHL = 4'd6, ACT_SHR = 4'd7,
		ACT_MUL = 4'd8, ACT_DIV = 4'd9, ACT_REM = 4'd10
	} act_t;

	localparam logic [1:0] CMP_EQ = 2'b00;
	localparam logic [1:0] CMP_GT = 2'b01;
	localparam logic [1:0] CMP_LT = 2'b11;

	// Class of work the back end must do for a command.
	typedef enum logic [1:0] {
		CLS_DONE = 2'd0,  // result already formed by the front end
		CLS_MUL  = 2'd1,
		CLS_DIV  = 2'd2
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic              want_rem;
		logic [FieldW-1:0] a;
		logic [FieldW-1:0] b;
		logic [FieldW-1:0] res;
		logic [1:0]        cmp;
		logic              dz;
	} cmd_t;
endpackage

FILE: rtl/core/unsigned_64bit_alu_mul_div_core.sv
// ----------------------------------------------------------------------------
// unsigned_64bit_alu_mul_div_core
// Unsigned integer unit: add, sub, logic, shifts, multiply, divide, remainder.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake           | Fields
// input    | in        | push / full         | action, operand_a, operand_b
// result   | out       | empty / pop         | result, compare, divide_by_zero
//
// Single-cycle operations pass from the front register through the queue and
// the back end's issue and output states into the result register.
// Multiply and divide step one bit per cycle in the back end, which takes no
// new command until it is done; the back end's bit loop sets the rate.
// The two-entry queue lets the front end keep accepting while the back end
// works, and the result register holds a transaction until it is popped.
// Reset (arst_n low) empties the queue and result register at once.
module unsigned_64bit_alu_mul_div_core #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  action,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] result,
	output logic [1:0]  compare,
	output logic        divide_by_zero
);
	import ualu_pkg::*;

	// Working width is capped at the 64-bit field width.
	localparam int unsigned W = (DATA_WIDTH > 64) ? 64 : DATA_WIDTH;

	logic f_valid, f_ready, q_valid, q_ready;
	cmd_t f_cmd, q_cmd;

	// Front end: single-cycle operations and classification of the rest.
	ualu_front #(.W(W)) u_front (
		.clk, .arst_n, .push, .full, .action, .operand_a, .operand_b,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	ualu_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
		.out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
	);

	// Back end: serial multiply and divide, then the result register.
	ualu_back #(.W(W)) u_back (
		.clk, .arst_n,
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.empty, .pop, .result, .compare, .divide_by_zero
	);
endmodule

FILE: rtl/core/ualu_front.sv
// ----------------------------------------------------------------------------
// ualu_front
// Accepts transactions, does single-cycle operations and classifies the rest.
// ----------------------------------------------------------------------------
module ualu_front #(
	parameter int unsigned W = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [3:0]                     action,
	input  logic [63:0]                    operand_a,
	input  logic [63:0]                    operand_b,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output ualu_pkg::cmd_t                 cmd
);
	import ualu_pkg::*;

	localparam int unsigned AW = $clog2(W + 1);

	logic [W-1:0] a, b, r;
	logic [63:0]  a64, b64, r64;
	logic         big, bzero;
	cls_t         cls;
	logic         want_rem;
	logic         dz;
	logic         valid_s1;
	cmd_t         cmd_s1;

	assign a = operand_a[W-1:0];
	assign b = operand_b[W-1:0];
	assign big = (operand_b >= 64'(W));
	assign bzero = (b == '0);

	always_comb begin
		r = '0;
		cls = CLS_DONE;
		want_rem = 1'b0;
		dz = 1'b0;
		case (action)
			ACT_ADD: r = a + b;
			ACT_SUB: r = a - b;
			ACT_AND: r = a & b;
			ACT_OR:  r = a | b;
			ACT_XOR: r = a ^ b;
			ACT_NOT: r = ~a;
			ACT_SHL: r = big ? '0 : (a << operand_b[AW-1:0]);
			ACT_SHR: r = big ? '0 : (a >> operand_b[AW-1:0]);
			ACT_MUL: cls = CLS_MUL;
			ACT_DIV, ACT_REM: begin
				want_rem = (action == ACT_REM);
				if (bzero) begin
					dz = 1'b1;
					r = (action == ACT_DIV) ? '1 : a;
				end else begin
					cls = CLS_DIV;
				end
			end
			default: r = '0;
		endcase
	end

	always_comb begin
		a64 = '0;
		b64 = '0;
		r64 = '0;
		a64[W-1:0] = a;
		b64[W-1:0] = b;
		r64[W-1:0] = r;
	end

	always_comb begin
		cmd = cmd_s1;
	end

	assign full = valid_s1 && !cmd_ready;
	assign cmd_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			cmd_s1.cls      <= cls;
			cmd_s1.want_rem <= want_rem;
			cmd_s1.dz       <= dz;
			cmd_s1.a        <= a64;
			cmd_s1.b        <= b64;
			cmd_s1.res      <= r64;
			cmd_s1.cmp      <= (a < b) ? CMP_LT : ((a > b) ? CMP_GT : CMP_EQ);
		end
	end
endmodule

FILE: rtl/core/ualu_queue.sv
// ----------------------------------------------------------------------------
// ualu_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ualu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ualu_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output ualu_pkg::cmd_t out_cmd
);
	import ualu_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd   = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_cmd;
	end
endmodule

FILE: rtl/core/ualu_back.sv
// ----------------------------------------------------------------------------
// ualu_back
// Bit-serial shift-add multiplier and restoring divider with a result register.
// ----------------------------------------------------------------------------
module ualu_back #(
	parameter int unsigned W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ualu_pkg::cmd_t cmd,
	output logic           empty,
	input  logic           pop,
	output logic [63:0]    result,
	output logic [1:0]     compare,
	output logic           divide_by_zero
);
	import ualu_pkg::*;

	localparam int unsigned CW = $clog2(W + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  x_q, y_q, acc_q, rem_q, d_q;
	logic          rem_sel_q;
	logic [1:0]    cmp_q;
	logic          dz_q;
	logic [63:0]   res_q;
	logic [1:0]    res_cmp_q;
	logic          res_dz_q;
	logic          out_v_q;
	logic [W-1:0]  rsh, rsub;
	logic          take;
	logic [63:0]   fin;
	logic          load;

	assign rsh  = {rem_q[W-2:0], x_q[W-1]};
	assign rsub = rsh - d_q;
	assign take = rem_q[W-1] || (rsh >= d_q);
	assign cmd_ready = (state_q == ST_IDLE);
	assign empty = !out_v_q;
	assign result = res_q;
	assign compare = res_cmp_q;
	assign divide_by_zero = res_dz_q;
	// The finished transaction moves into the result register once it is free.
	assign load = (state_q == ST_OUT) && (!out_v_q || pop);

	always_comb begin
		fin = '0;
		fin[W-1:0] = rem_sel_q ? rem_q : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			cnt_q <= '0;
			res_q <= '0;
			res_cmp_q <= CMP_EQ;
			res_dz_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				res_q <= fin;
				res_cmp_q <= cmp_q;
				res_dz_q <= dz_q;
			end else if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cnt_q <= CW'(W);
						case (cmd.cls)
							CLS_MUL: state_q <= ST_MUL;
							CLS_DIV: state_q <= ST_DIV;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MUL, ST_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_v_q || pop) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= cmd.a[W-1:0];
				y_q <= cmd.b[W-1:0];
				d_q <= cmd.b[W-1:0];
				acc_q <= (cmd.cls == CLS_MUL || cmd.cls == CLS_DIV) ? '0 : cmd.res[W-1:0];
				rem_q <= '0;
				rem_sel_q <= (cmd.cls == CLS_DIV) && cmd.want_rem;
				cmp_q <= cmd.cmp;
				dz_q <= cmd.dz;
			end
			ST_MUL: begin
				if (y_q[0]) acc_q <= acc_q + x_q;
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end
			ST_DIV: begin
				x_q <= x_q << 1;
				rem_q <= take ? rsub : rsh;
				acc_q <= {acc_q[W-2:0], take};
			end
			default: ;
		endcase
	end
endmodule

FILE: rtl/core/ualu_checker.sv
// ----------------------------------------------------------------------------
// ualu_checker
// Port-level checks on the unsigned integer unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ualu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [63:0] result,
	input logic [1:0]  compare,
	input logic        divide_by_zero
);
	`ASSERT_NEXT(a_stay, clk, arst_n, !empty && !pop, !empty, "result withdrawn")
	`ASSERT_NEXT(a_res, clk, arst_n, !empty && !pop, $stable(result), "result changed")
	`ASSERT_NEXT(a_flags, clk, arst_n, !empty && !pop, $stable({compare, divide_by_zero}), "flags changed")
	`ASSERT_IMPL(a_cmp, clk, arst_n, !empty, compare != 2'b10, "illegal compare code")
endmodule

bind unsigned_64bit_alu_mul_div_core ualu_checker u_checker (
	.clk, .arst_n, .empty, .pop, .result, .compare, .divide_by_zero
);

FILE: bench/unsigned_64bit_alu_mul_div_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned integer unit testbench
// Feeds a directed set of operations and then random ones through the queue
// interface. Every result is checked against a local behavioural model, with
// random stalls on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module unsigned_64bit_alu_mul_div_core_tb;
	import ualu_pkg::*;

	// One result transaction as the core presents it.
	typedef struct {
		logic [63:0] res;
		logic [1:0]  cmp;
		logic        dz;
	} outcome_t;

	// One row of the directed table. When has_gold is set, the typed-in
	// result is checked as well as the model's answer.
	typedef struct {
		logic [3:0]  act;
		logic [63:0] a;
		logic [63:0] b;
		logic        has_gold;
		logic [63:0] gold;
	} row_t;

	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int unsigned N_RANDOM = 2000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [3:0]  action;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	logic        empty;
	logic        pop;
	logic [63:0] result;
	logic [1:0]  compare;
	logic        divide_by_zero;

	outcome_t    pending_outcomes[$];
	int unsigned n_errors;
	int unsigned n_checked;
	int unsigned n_sent;
	int unsigned n_divzero;
	bit          stim_done;
	bit          hold_off;
	bit          calm;

	unsigned_64bit_alu_mul_div_core #(
		.DATA_WIDTH(64)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.empty(empty),
		.pop(pop),
		.result(result),
		.compare(compare),
		.divide_by_zero(divide_by_zero)
	);

	// Free-running 100 MHz clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Bit-serial multiply keeping the low 64 bits, as the core's back end does.
	function automatic logic [63:0] mul_low(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] acc;
		acc = '0;
		for (int i = 0; i < 64; i++) begin
			if (y[i]) begin
				acc = acc + (x << i);
			end
		end
		return acc;
	endfunction

	// Restoring division; the carry out of the partial remainder is kept
	// in a 65-bit register so a full-width divisor is handled.
	function automatic void div_restoring(input logic [63:0] n, input logic [63:0] d,
			output logic [63:0] q, output logic [63:0] r);
		logic [64:0] part;
		part = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			part = {part[63:0], n[i]};
			if (part >= {1'b0, d}) begin
				part = part - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		r = part[63:0];
	endfunction

	// Works out the expected transaction for one accepted command.
	function automatic outcome_t alu_outcome(input logic [3:0] act, input logic [63:0] a,
			input logic [63:0] b);
		outcome_t    o;
		logic [63:0] q;
		logic [63:0] r;
		o.res = '0;
		o.dz = 1'b0;
		case (act)
			ACT_ADD: o.res = a + b;
			ACT_SUB: o.res = a - b;
			ACT_AND: o.res = a & b;
			ACT_OR:  o.res = a | b;
			ACT_XOR: o.res = a ^ b;
			ACT_NOT: o.res = ~a;
			// Any amount of 64 or more clears the value; every bit of b counts.
			ACT_SHL: o.res = (b >= 64) ? '0 : a << b[5:0];
			ACT_SHR: o.res = (b >= 64) ? '0 : a >> b[5:0];
			ACT_MUL: o.res = mul_low(a, b);
			ACT_DIV, ACT_REM: begin
				if (b == '0) begin
					o.dz = 1'b1;
					o.res = (act == ACT_DIV) ? ONES : a;
				end else begin
					div_restoring(a, b, q, r);
					o.res = (act == ACT_DIV) ? q : r;
				end
			end
			default: o.res = '0;
		endcase
		if (a < b) begin
			o.cmp = CMP_LT;
		end else if (a > b) begin
			o.cmp = CMP_GT;
		end else begin
			o.cmp = CMP_EQ;
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		n_errors++;
		$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Drives one command and holds it until the core takes it.
	task automatic send_command(input logic [3:0] act, input logic [63:0] a,
			input logic [63:0] b);
		while (!calm && ($urandom_range(99) < 9)) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		operand_a <= a;
		operand_b <= b;
		pending_outcomes.push_back(alu_outcome(act, a, b));
		if (act inside {ACT_DIV, ACT_REM} && b == '0) begin
			n_divzero++;
		end
		n_sent++;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
	endtask

	// Operands biased towards the edges of the range.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(7))
			0: return '0;
			1: return ONES;
			2: return 64'(1) << $urandom_range(63);
			3: return 64'($urandom_range(70));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] pick_shift();
		case ($urandom_range(5))
			0: return 64'($urandom_range(63));
			1: return 64'($urandom_range(80));
			2: return 64'(1) << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Result side: checks each popped transaction against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("unexpected transaction", result, '0);
			end else begin
				outcome_t want;
				want = pending_outcomes.pop_front();
				n_checked++;
				if (result !== want.res) report_mismatch("result", result, want.res);
				if (compare !== want.cmp) begin
					report_mismatch("compare", 64'(compare), 64'(want.cmp));
				end
				if (divide_by_zero !== want.dz) begin
					report_mismatch("divide_by_zero", 64'(divide_by_zero), 64'(want.dz));
				end
			end
		end
	end

	// Pop is driven at the edge: random stalls, none in the calm stretch,
	// and held low throughout the long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_off) begin
			pop <= 1'b0;
		end else begin
			pop <= calm || ($urandom_range(99) >= 9);
		end
	end

	// The receiver stops popping for a long stretch once traffic is under way,
	// so the queue fills and full must stall the sender.
	initial begin
		hold_off = 1'b0;
		wait (n_sent >= 40);
		@(posedge clk);
		hold_off = 1'b1;
		for (int i = 0; i < 600; i++) begin
			@(posedge clk);
		end
		hold_off = 1'b0;
	end

	// Directed table followed by random traffic.
	initial begin
		row_t        table_rows[$];
		row_t        row;
		logic [3:0]  act;
		logic [63:0] a;
		logic [63:0] b;
		outcome_t    o;
		push = 1'b0;
		action = '0;
		operand_a = '0;
		operand_b = '0;
		arst_n = 1'b0;
		n_errors = 0;
		n_checked = 0;
		n_sent = 0;
		n_divzero = 0;
		stim_done = 1'b0;
		calm = 1'b0;

		table_rows = '{
			'{ACT_ADD, ONES, 64'd1, 1'b1, 64'd0},
			'{ACT_SUB, 64'd0, 64'd1, 1'b1, ONES},
			'{ACT_AND, ONES, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 64'h0F0F_0F0F_0F0F_0F0F},
			'{ACT_OR, 64'd0, 64'd0, 1'b1, 64'd0},
			'{ACT_XOR, ONES, ONES, 1'b1, 64'd0},
			'{ACT_NOT, 64'd0, ONES, 1'b1, ONES},
			'{ACT_SHL, ONES, 64'd0, 1'b1, ONES},
			'{ACT_SHL, 64'd1, 64'd32, 1'b1, 64'h0000_0001_0000_0000},
			'{ACT_SHL, 64'd1, 64'd63, 1'b1, 64'h8000_0000_0000_0000},
			'{ACT_SHL, ONES, 64'd64, 1'b1, 64'd0},
			'{ACT_SHR, ONES, 64'd32, 1'b1, 64'h0000_0000_FFFF_FFFF},
			'{ACT_SHR, ONES, 64'h8000_0000_0000_0000, 1'b1, 64'd0},
			'{ACT_SHR, 64'h8000_0000, 64'd0, 1'b1, 64'h8000_0000},
			'{ACT_MUL, ONES, ONES, 1'b1, 64'd1},
			'{ACT_MUL, 64'h8000_0000, 64'h8000_0000, 1'b0, 64'd0},
			'{ACT_DIV, 64'd12345, 64'd0, 1'b1, ONES},
			'{ACT_REM, 64'd12345, 64'd0, 1'b1, 64'd12345},
			'{ACT_DIV, ONES, ONES, 1'b1, 64'd1},
			'{ACT_DIV, ONES, 64'd1, 1'b1, ONES},
			'{ACT_REM, ONES, 64'h8000_0000_0000_0001, 1'b0, 64'd0},
			'{ACT_DIV, 64'd5, 64'd7, 1'b1, 64'd0},
			'{4'd11, ONES, 64'd1, 1'b1, 64'd0},
			'{4'd15, 64'd0, 64'd0, 1'b1, 64'd0}
		};

		for (int i = 0; i < 10; i++) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: typed-in values are checked against the model up front,
		// and the core is then checked against the model as usual.
		foreach (table_rows[i]) begin
			row = table_rows[i];
			o = alu_outcome(row.act, row.a, row.b);
			if (row.has_gold && o.res !== row.gold) begin
				report_mismatch($sformatf("directed row %0d", i), o.res, row.gold);
			end
			send_command(row.act, row.a, row.b);
		end

		// Random part, with a stretch in the middle where neither side idles.
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 800 && n < 1000);
			act = (($urandom_range(99) < 4) ? 4'($urandom_range(15, 11))
				: 4'($urandom_range(10)));
			a = pick_operand();
			b = (act == ACT_SHL || act == ACT_SHR) ? pick_shift() : pick_operand();
			send_command(act, a, b);
		end
		calm = 1'b0;
		push <= 1'b0;
		stim_done = 1'b1;
	end

	// End of run: drain, allow the core's multiply latency to pass, then judge.
	initial begin
		wait (stim_done);
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
		for (int i = 0; i < 100; i++) begin
			@(posedge clk);
		end
		$display("Ran %0d commands over all actions and unused codes, %0d with a zero divisor.",
			n_sent, n_divzero);
		$display("Checked %0d result transactions under random stalls and a long hold-off.",
			n_checked);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
